FILE: sv/adh_pkg.sv
// Shared constants, types and helper functions of the attractor density histogram.
package adh_pkg;

  localparam int MAX_DIM      = 1024;
  localparam int COUNT_BITS   = 32;
  localparam int CORDIC_STEPS = 18;

  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ITER_BITS  = $clog2(CORDIC_STEPS);
  localparam int ANG_W      = 24;
  localparam int CRD_W      = 20;
  localparam int POS_W      = 19;
  localparam int COEF_W     = 20;
  localparam int DIM_W      = 11;
  localparam int FLD_W      = 10;
  localparam int PROD_W     = 32;
  localparam int BIN_W      = 14;
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] FUNC_STEP    = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_W = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_H = 3'd5;

  localparam logic signed [ANG_W-1:0] TWO_PI  = 24'sd411775;
  localparam logic signed [ANG_W-1:0] PI      = 24'sd205887;
  localparam logic signed [ANG_W-1:0] HALF_PI = 24'sd102944;
  localparam logic signed [CRD_W-1:0] GAIN    = 20'sd39797;
  localparam logic signed [POS_W-1:0] ONE_Q16 = 19'sd65536;
  localparam logic signed [20:0]      COORD_LIMIT = 21'sd131072;

  typedef struct packed {
    logic                 clear;
    logic                 take_in;
    logic                 bin_mul;
    logic                 bin_calc;
    logic                 use_count;
    logic                 arg_load;
    logic                 reduce;
    logic                 fold;
    logic                 rot;
    logic                 take;
    logic [1:0]           sel;
    logic [ITER_BITS-1:0] iter;
    logic                 load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic ang_ok;
  } sts_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ITER_BITS-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (32'(i))
      0: v = 24'sd51472;
      1: v = 24'sd30386;
      2: v = 24'sd16055;
      3: v = 24'sd8150;
      4: v = 24'sd4091;
      5: v = 24'sd2047;
      6: v = 24'sd1024;
      7: v = 24'sd512;
      8: v = 24'sd256;
      9: v = 24'sd128;
      10: v = 24'sd64;
      11: v = 24'sd32;
      12: v = 24'sd16;
      13: v = 24'sd8;
      14: v = 24'sd4;
      15: v = 24'sd2;
      16: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_coord(input logic signed [20:0] v);
    logic signed [POS_W-1:0] r;
    if (v > COORD_LIMIT) r = POS_W'(COORD_LIMIT);
    else if (v < -COORD_LIMIT) r = POS_W'(-COORD_LIMIT);
    else r = POS_W'(v);
    return r;
  endfunction

endpackage

FILE: sv/adh_ctrl.sv
// Sequencing state machine of the attractor density histogram.
module adh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          func,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  adh_pkg::sts_t       sts,
  output adh_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BMUL, S_BIN, S_RD, S_CNT, S_ARG, S_RED, S_FOLD, S_ROT, S_TAKE, S_OUT
  } state_t;

  localparam logic [adh_pkg::ITER_BITS-1:0] ITER_LAST =
    adh_pkg::ITER_BITS'(adh_pkg::CORDIC_STEPS - 1);

  state_t                        state;
  logic [1:0]                    sel;
  logic [adh_pkg::ITER_BITS-1:0] iter;
  logic                          is_step;
  logic                          out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd      = '0;
    cmd.sel  = sel;
    cmd.iter = iter;
    case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE:  cmd.take_in = s_tvalid;
      S_BMUL:  cmd.bin_mul = 1'b1;
      S_BIN:   cmd.bin_calc = 1'b1;
      S_CNT:   cmd.use_count = 1'b1;
      S_ARG:   cmd.arg_load = 1'b1;
      S_RED:   cmd.reduce = !sts.ang_ok;
      S_FOLD:  cmd.fold = 1'b1;
      S_ROT:   cmd.rot = 1'b1;
      S_TAKE:  cmd.take = 1'b1;
      S_OUT:   cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      sel      <= '0;
      iter     <= '0;
      is_step  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: if (sts.clear_done) state <= S_IDLE;
        S_IDLE: begin
          if (s_tvalid) begin
            is_step <= (func == adh_pkg::FUNC_STEP);
            case (func)
              adh_pkg::FUNC_STEP: state <= S_BMUL;
              adh_pkg::FUNC_READ: state <= S_RD;
              default:            state <= S_OUT;
            endcase
          end
        end
        S_BMUL: state <= S_BIN;
        S_BIN:  state <= S_RD;
        S_RD:   state <= S_CNT;
        S_CNT: begin
          sel   <= '0;
          state <= is_step ? S_ARG : S_OUT;
        end
        S_ARG: state <= S_RED;
        S_RED: if (sts.ang_ok) state <= S_FOLD;
        S_FOLD: begin
          iter  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (iter == ITER_LAST) state <= S_TAKE;
          else iter <= iter + 1'b1;
        end
        S_TAKE: begin
          if (sel == 2'd3) state <= S_OUT;
          else begin
            sel   <= sel + 1'b1;
            state <= S_ARG;
          end
        end
        S_OUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/adh_dp.sv
// Datapath: config registers, point, binning, CORDIC, counter memory and result word.
module adh_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  adh_pkg::cmd_t                       cmd,
  output adh_pkg::sts_t                       sts,
  input  logic                                cfg_we,
  input  logic [adh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [adh_pkg::COEF_W-1:0]          cfg_data,
  input  logic [1:0]                          func_in,
  input  logic [adh_pkg::FLD_W-1:0]           col_in,
  input  logic [adh_pkg::FLD_W-1:0]           row_in,
  output logic signed [adh_pkg::POS_W-1:0]    point_x,
  output logic signed [adh_pkg::POS_W-1:0]    point_y,
  output logic [adh_pkg::FLD_W-1:0]           bin_col,
  output logic [adh_pkg::FLD_W-1:0]           bin_row,
  output logic                                bin_hit,
  output logic [adh_pkg::OUT_CNT_W-1:0]       bin_count
);

  localparam int AW = adh_pkg::ADDR_W;
  localparam int CW = adh_pkg::COUNT_BITS;
  localparam int BW = adh_pkg::BIN_W;
  localparam int PW = adh_pkg::PROD_W;
  localparam logic [CW-1:0] CMAX = '1;

  logic signed [adh_pkg::COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;
  logic [adh_pkg::DIM_W-1:0]         grid_width, grid_height;

  logic signed [adh_pkg::POS_W-1:0]  pos_x, pos_y, nx;
  logic signed [adh_pkg::CRD_W-1:0]  s_keep, cx, cy;
  logic signed [adh_pkg::ANG_W-1:0]  ang;
  logic                              neg;
  logic signed [PW-1:0]              prod_x, prod_y;
  logic [1:0]                        func_q;
  logic                              rd_ok;
  logic [AW-1:0]                     bin_addr, clr_addr;
  logic [CW-1:0]                     mem [adh_pkg::DEPTH];
  logic [CW-1:0]                     rdata, inc;
  logic                              mem_we;
  logic [AW-1:0]                     waddr;
  logic [CW-1:0]                     wdata;

  logic [adh_pkg::FLD_W-1:0]         res_col, res_row;
  logic                              res_hit;
  logic [adh_pkg::OUT_CNT_W-1:0]     res_count;

  logic signed [adh_pkg::COEF_W-1:0] coef_sel;
  logic signed [adh_pkg::POS_W-1:0]  pos_sel;
  logic signed [38:0]                arg_sum;
  logic signed [adh_pkg::ANG_W-1:0]  ang_w, atan_v;
  logic signed [adh_pkg::CRD_W-1:0]  sin_v, cos_v, cy_sh, cx_sh;
  logic signed [20:0]                diff;
  logic signed [BW-1:0]              bc, br;
  logic                              hit_w;

  function automatic logic signed [BW-1:0] bin_of(input logic signed [PW-1:0] prod,
                                                   input logic [adh_pkg::DIM_W-1:0] dim);
    logic [PW-1:0]        offs, mag, mag2, q;
    logic signed [PW-1:0] n;
    logic                 sgn;
    offs = PW'(dim[adh_pkg::DIM_W-1:1]) * PW'(327680);
    n    = prod + $signed(offs);
    sgn  = n[PW-1];
    mag  = sgn ? PW'(-n) : PW'(n);
    mag2 = mag + PW'(163840);
    q    = (PW'(mag2[PW-1:16]) * PW'(52429)) >> 18;
    return sgn ? -$signed(BW'(q)) : $signed(BW'(q));
  endfunction

  assign sts.clear_done = (clr_addr == AW'(adh_pkg::DEPTH - 1));
  assign sts.ang_ok     = !ang[adh_pkg::ANG_W-1] && (ang < adh_pkg::TWO_PI);

  always_comb begin
    case (cmd.sel)
      2'd0:    begin coef_sel = coef_a; pos_sel = pos_y; end
      2'd1:    begin coef_sel = coef_b; pos_sel = pos_x; end
      2'd2:    begin coef_sel = coef_c; pos_sel = pos_x; end
      default: begin coef_sel = coef_d; pos_sel = pos_y; end
    endcase
  end

  assign arg_sum = 39'(coef_sel * pos_sel) + 39'sd32768;
  assign ang_w   = (ang > adh_pkg::PI) ? ang - adh_pkg::TWO_PI : ang;
  assign atan_v  = adh_pkg::atan_q16(cmd.iter);
  assign cy_sh   = cy >>> cmd.iter;
  assign cx_sh   = cx >>> cmd.iter;
  assign sin_v   = neg ? -cy : cy;
  assign cos_v   = neg ? -cx : cx;
  assign diff    = 21'(s_keep) - 21'(cos_v);

  assign bc    = bin_of(prod_x, grid_width);
  assign br    = bin_of(prod_y, grid_height);
  assign hit_w = !bc[BW-1] && !br[BW-1] &&
                 (32'(bc[BW-2:0]) < 32'(grid_width)) &&
                 (32'(br[BW-2:0]) < 32'(grid_height)) &&
                 (32'(bc[BW-2:0]) < 32'(adh_pkg::MAX_DIM)) &&
                 (32'(br[BW-2:0]) < 32'(adh_pkg::MAX_DIM));

  assign inc    = (rdata == CMAX) ? rdata : rdata + 1'b1;
  assign mem_we = cmd.clear || (cmd.use_count && func_q == adh_pkg::FUNC_STEP && res_hit);
  assign waddr  = cmd.clear ? clr_addr : bin_addr;
  assign wdata  = cmd.clear ? '0 : inc;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[bin_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear && !sts.clear_done) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a      <= 20'sd65536;
      coef_b      <= 20'sd65536;
      coef_c      <= 20'sd65536;
      coef_d      <= 20'sd65536;
      grid_width  <= 11'd1024;
      grid_height <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        adh_pkg::REG_COEF_A: coef_a <= $signed(cfg_data);
        adh_pkg::REG_COEF_B: coef_b <= $signed(cfg_data);
        adh_pkg::REG_COEF_C: coef_c <= $signed(cfg_data);
        adh_pkg::REG_COEF_D: coef_d <= $signed(cfg_data);
        adh_pkg::REG_GRID_W: grid_width <= cfg_data[adh_pkg::DIM_W-1:0];
        adh_pkg::REG_GRID_H: grid_height <= cfg_data[adh_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= adh_pkg::ONE_Q16;
      pos_y <= adh_pkg::ONE_Q16;
    end else if (cmd.take_in && func_in == adh_pkg::FUNC_RESTART) begin
      pos_x <= adh_pkg::ONE_Q16;
      pos_y <= adh_pkg::ONE_Q16;
    end else if (cmd.take && cmd.sel == 2'd3) begin
      pos_x <= nx;
      pos_y <= adh_pkg::sat_coord(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      func_q    <= func_in;
      res_col   <= col_in;
      res_row   <= row_in;
      res_hit   <= 1'b0;
      res_count <= '0;
      bin_addr  <= AW'(AW'(row_in) * AW'(adh_pkg::MAX_DIM) + AW'(col_in));
      rd_ok     <= (32'(col_in) < 32'(adh_pkg::MAX_DIM)) &&
                   (32'(row_in) < 32'(adh_pkg::MAX_DIM));
    end
    if (cmd.bin_mul) begin
      prod_x <= PW'(pos_x * $signed({1'b0, grid_width}));
      prod_y <= PW'(pos_y * $signed({1'b0, grid_height}));
    end
    if (cmd.bin_calc) begin
      res_col  <= bc[adh_pkg::FLD_W-1:0];
      res_row  <= br[adh_pkg::FLD_W-1:0];
      res_hit  <= hit_w;
      bin_addr <= AW'(AW'(br[BW-2:0]) * AW'(adh_pkg::MAX_DIM) + AW'(bc[BW-2:0]));
    end
    if (cmd.use_count) begin
      if (func_q == adh_pkg::FUNC_STEP) begin
        if (res_hit) res_count <= adh_pkg::OUT_CNT_W'(inc);
      end else if (func_q == adh_pkg::FUNC_READ) begin
        res_count <= rd_ok ? adh_pkg::OUT_CNT_W'(rdata) : '0;
      end
    end
    if (cmd.arg_load) ang <= adh_pkg::ANG_W'($signed(arg_sum[38:16]));
    if (cmd.reduce) ang <= ang[adh_pkg::ANG_W-1] ? ang + adh_pkg::TWO_PI
                                                 : ang - adh_pkg::TWO_PI;
    if (cmd.fold) begin
      cx <= adh_pkg::GAIN;
      cy <= '0;
      if (ang_w > adh_pkg::HALF_PI) begin
        ang <= ang_w - adh_pkg::PI;
        neg <= 1'b1;
      end else if (ang_w < -adh_pkg::HALF_PI) begin
        ang <= ang_w + adh_pkg::PI;
        neg <= 1'b1;
      end else begin
        ang <= ang_w;
        neg <= 1'b0;
      end
    end
    if (cmd.rot) begin
      if (!ang[adh_pkg::ANG_W-1]) begin
        cx  <= cx - cy_sh;
        cy  <= cy + cx_sh;
        ang <= ang - atan_v;
      end else begin
        cx  <= cx + cy_sh;
        cy  <= cy - cx_sh;
        ang <= ang + atan_v;
      end
    end
    if (cmd.take) begin
      if (cmd.sel == 2'd0 || cmd.sel == 2'd2) s_keep <= sin_v;
      if (cmd.sel == 2'd1) nx <= adh_pkg::sat_coord(diff);
    end
    if (cmd.load_out) begin
      point_x   <= pos_x;
      point_y   <= pos_y;
      bin_col   <= res_col;
      bin_row   <= res_row;
      bin_hit   <= res_hit;
      bin_count <= res_count;
    end
  end

endmodule

FILE: sv/attractor_density_histogram.sv
// Top level of the attractor density histogram.
// After reset the block sweeps the 1048576-entry counter memory to zero, one
// entry per cycle, and accepts no word until the sweep is done; config writes
// are taken throughout. A step word goes through binning and the counter
// read-modify-write, then four sine/cosine evaluations run one after another
// on a single CORDIC unit, each an argument multiply, modulo reduction, a
// fold, 18 rotations and a capture, and then the result is loaded. A read word
// goes through the counter read before its result is loaded; restart and
// unused codes go straight to the result load. Each also waits at the result
// load while the previous result is still unaccepted. One word is in work at
// a time; a finished result waits in the output register while the next word is taken.
module attractor_density_histogram (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // read_col[9:0], read_row[19:10], zero pad
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // point_x[18:0], point_y[37:19], bin_col[47:38],
                                 // bin_row[57:48], bin_count[89:58], zero pad
  output logic [0:0]  m_tuser,   // bin_hit[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  adh_pkg::cmd_t cmd;
  adh_pkg::sts_t sts;

  logic signed [adh_pkg::POS_W-1:0] point_x, point_y;
  logic [adh_pkg::FLD_W-1:0]        bin_col, bin_row;
  logic                             bin_hit;
  logic [adh_pkg::OUT_CNT_W-1:0]    bin_count;

  adh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  adh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .func_in   (s_tuser),
    .col_in    (s_tdata[9:0]),
    .row_in    (s_tdata[19:10]),
    .point_x   (point_x),
    .point_y   (point_y),
    .bin_col   (bin_col),
    .bin_row   (bin_row),
    .bin_hit   (bin_hit),
    .bin_count (bin_count)
  );

  assign m_tdata = {6'd0, bin_count, bin_row, bin_col, point_y, point_x};
  assign m_tuser = bin_hit;

endmodule
